FILE: hw/rtl/arm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_pkg: shared types and constants for the address region map
// Table geometry, command and status codes, and the sequencer state type.
// ----------------------------------------------------------------------------
package arm_pkg;

  localparam int unsigned MaxEntries = 64;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned CfgW       = 32;
  localparam int unsigned CfgIdxW    = 2;

  localparam logic [CfgIdxW-1:0] CFG_WINDOW_START = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_WINDOW_END   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_ALIGN_LOG2   = 2'd2;

  localparam logic [31:0] WINDOW_START_RST = 32'd16384;
  localparam logic [31:0] WINDOW_END_RST   = 32'd1073740800;
  localparam logic [4:0]  ALIGN_LOG2_RST   = 5'd2;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_LOOKUP = 2'd1;
  localparam logic [1:0] CMD_CLEAR  = 2'd2;
  localparam logic [1:0] CMD_UNUSED = 2'd3;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_FIT   = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]  command;
    logic        auto_place;
    logic [31:0] address;
    logic [31:0] length;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] region_start;
    logic [31:0] region_length;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_HIT_RD,    // read last-hit entry
    S_HIT_CHK,
    S_SCAN,      // lookup scan
    S_PLACE,     // auto placement scan
    S_PLACE_END, // evaluate candidate
    S_POS,       // find insert position
    S_SHIFT_RD,  // shift entries up one by one
    S_SHIFT_WR,
    S_WRITE,
    S_DONE
  } state_t;

endpackage

FILE: hw/rtl/arm_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_if: valid/ready channel
// Carries one word of a generic payload type between a source and a sink.
// ----------------------------------------------------------------------------
interface arm_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/arm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_ram: generic single-port RAM
// One write or read per cycle, read data registered.
// ----------------------------------------------------------------------------
module arm_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

FILE: hw/rtl/address_region_map.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// address_region_map: sorted region table with automatic placement
// Insert, lookup and clear on a table of (start, length) regions in RAM.
// ----------------------------------------------------------------------------
// One command word is taken at a time and one response word is returned for
// each. The table lives in a single-port RAM holding start and length side by
// side, so every step that touches an entry takes one RAM access. A lookup
// first checks the last hit entry, if one is held, and scans the table when
// that entry no longer covers the address. An insert scans for its slot,
// shifts the entries above it up one by one and stores the region; automatic
// placement adds a further scan of the table before that. The next command is
// taken only once the response word has left the output register.
module address_region_map (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [arm_pkg::CfgIdxW-1:0] cfg_index,
  input  logic [arm_pkg::CfgW-1:0]  cfg_data,
  arm_if.sink                       req,
  arm_if.source                     rsp
);
  import arm_pkg::*;

  // Configuration registers.
  logic [31:0] window_start, window_end;
  logic [4:0]  align_log2;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_start <= WINDOW_START_RST;
      window_end   <= WINDOW_END_RST;
      align_log2   <= ALIGN_LOG2_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_WINDOW_START: window_start <= cfg_data[31:0];
        CFG_WINDOW_END:   window_end   <= cfg_data[31:0];
        CFG_ALIGN_LOG2:   align_log2   <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Control state.
  state_t          state, state_next;
  logic [CntW-1:0] count;
  logic [CntW-1:0] last_hit;
  logic [CntW-1:0] idx;       // scan pointer, counts up to count
  req_t            cur;
  logic [31:0]     ins_start; // start to be stored
  logic            have_a, have_b, in_a_run;
  logic [32:0]     a_end;     // end of the last region in the window
  logic [31:0]     b_start;
  logic            out_valid;
  rsp_t            out_word;

  // Table RAM: start in the upper half, length in the lower half.
  logic            ram_we;
  logic [IdxW-1:0] ram_addr;
  logic [63:0]     ram_wdata, ram_rdata;
  logic [31:0]     rd_start, rd_len;
  logic [32:0]     rd_end;

  arm_ram #(.Width(64), .Depth(MaxEntries)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign rd_start = ram_rdata[63:32];
  assign rd_len   = ram_rdata[31:0];
  assign rd_end   = {1'b0, rd_start} + {1'b0, rd_len};

  // Take a new word only with the output register free and the sequencer idle.
  assign req.ready = (state == S_IDLE) && !out_valid;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_word;

  logic accept;
  assign accept = req.valid && req.ready;

  // Pending RAM read: the entry read at idx shows on ram_rdata in the next cycle.
  logic            rd_pend;   // data on ram_rdata belongs to idx - 1
  logic [CntW-1:0] rd_idx;

  // Candidate for automatic placement. Rounding up a 33-bit end can carry
  // past bit 32, so hold the candidate and its end in 35 bits.
  logic [34:0] mask, cand, cand_end, bound;
  assign mask     = (35'd1 << align_log2) - 35'd1;
  assign cand     = have_a ? (({2'b0, a_end} + mask) & ~mask) : {3'b0, window_start};
  assign cand_end = cand + {3'b0, cur.length};
  assign bound    = have_b ? {3'b0, b_start} : {3'b0, window_end};

  logic covers;
  assign covers = ({1'b0, rd_start} <= {1'b0, cur.address}) &&
                  ({1'b0, cur.address} < rd_end);

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.data.command)
            CMD_INSERT: begin
              if (count == CntW'(MaxEntries)) state_next = S_DONE;
              else if (req.data.auto_place)   state_next = S_PLACE;
              else                            state_next = S_POS;
            end
            CMD_LOOKUP: begin
              if (last_hit < count) state_next = S_HIT_RD;
              else                  state_next = S_SCAN;
            end
            default: state_next = S_DONE;
          endcase
        end
      end
      S_HIT_RD:  state_next = S_HIT_CHK;
      S_HIT_CHK: state_next = covers ? S_DONE : S_SCAN;
      S_SCAN: begin
        if (rd_pend && covers) state_next = S_DONE;
        else if (!rd_pend && idx >= count) state_next = S_DONE;
      end
      S_PLACE: begin
        if (rd_pend && have_a && in_a_run && {1'b0, rd_start} >= {1'b0, window_end})
          state_next = S_PLACE_END;
        else if (!rd_pend && idx >= count) state_next = S_PLACE_END;
      end
      S_PLACE_END: begin
        if (cand < {3'b0, window_start} || cand_end > bound) state_next = S_DONE;
        else state_next = S_POS;
      end
      S_POS: begin
        if (rd_pend && rd_start > ins_start) state_next = S_SHIFT_RD;
        else if (!rd_pend && idx >= count) state_next = S_SHIFT_RD;
      end
      S_SHIFT_RD: state_next = (idx == rd_idx) ? S_WRITE : S_SHIFT_WR;
      S_SHIFT_WR: state_next = S_SHIFT_RD;
      S_WRITE:    state_next = S_DONE;
      S_DONE:     state_next = S_IDLE;
      default:    state_next = S_IDLE;
    endcase
  end

  // RAM port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = idx[IdxW-1:0];
    ram_wdata = ram_rdata;
    case (state)
      S_HIT_RD:   ram_addr = last_hit[IdxW-1:0];
      S_SHIFT_RD: ram_addr = IdxW'(idx - CntW'(1));
      S_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_addr  = idx[IdxW-1:0];
        ram_wdata = ram_rdata;
      end
      S_WRITE: begin
        ram_we    = 1'b1;
        ram_addr  = rd_idx[IdxW-1:0];
        ram_wdata = {ins_start, cur.length};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      last_hit  <= CntW'(MaxEntries);
      out_valid <= 1'b0;
      idx       <= '0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp.valid && rsp.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            cur       <= req.data;
            ins_start <= req.data.address;
            idx       <= '0;
            rd_pend   <= 1'b0;
            have_a    <= 1'b0;
            have_b    <= 1'b0;
            in_a_run  <= 1'b0;
            out_word.region_start  <= '0;
            out_word.region_length <= '0;
            // Full table and the unused command answer at once.
            case (req.data.command)
              CMD_INSERT:
                out_word.status <= (count == CntW'(MaxEntries)) ? ST_FULL : ST_OK;
              CMD_LOOKUP, CMD_CLEAR: out_word.status <= ST_OK;
              default: out_word.status <= ST_NOT_FOUND;
            endcase
            if (req.data.command == CMD_CLEAR) begin
              count    <= '0;
              last_hit <= CntW'(MaxEntries);
            end
          end
        end
        S_HIT_CHK: begin
          if (covers) begin
            out_word.region_start  <= rd_start;
            out_word.region_length <= rd_len;
          end else begin
            last_hit <= CntW'(MaxEntries);
          end
        end
        S_SCAN: begin
          // Issue a read of idx each cycle; check the previous one.
          if (rd_pend && covers) begin
            last_hit               <= rd_idx;
            out_word.region_start  <= rd_start;
            out_word.region_length <= rd_len;
          end else if (!rd_pend && idx >= count) begin
            last_hit        <= CntW'(MaxEntries);
            out_word.status <= ST_NOT_FOUND;
          end else begin
            rd_pend <= idx < count;
            rd_idx  <= idx;
            if (idx < count) idx <= idx + CntW'(1);
          end
        end
        S_PLACE: begin
          if (rd_pend) begin
            if (!have_a) begin
              if ({1'b0, rd_start} >= {1'b0, window_start}) begin
                have_a   <= 1'b1;
                in_a_run <= 1'b1;
                a_end    <= rd_end;
              end
            end else if ({1'b0, rd_start} >= {1'b0, window_end}) begin
              have_b  <= 1'b1;
              b_start <= rd_start;
            end else begin
              a_end <= rd_end;
            end
          end
          rd_pend <= idx < count;
          rd_idx  <= idx;
          if (idx < count) idx <= idx + CntW'(1);
        end
        S_PLACE_END: begin
          idx     <= '0;
          rd_pend <= 1'b0;
          if (cand < {3'b0, window_start} || cand_end > bound)
            out_word.status <= ST_NO_FIT;
          else
            ins_start <= cand[31:0];
        end
        S_POS: begin
          if (rd_pend && rd_start > ins_start) begin
            idx <= count; // rd_idx holds the insert slot
          end else if (!rd_pend && idx >= count) begin
            rd_idx <= count;
            idx    <= count;
          end else begin
            rd_pend <= idx < count;
            rd_idx  <= idx;
            if (idx < count) idx <= idx + CntW'(1);
          end
        end
        S_SHIFT_WR: idx <= idx - CntW'(1);
        S_WRITE: begin
          count                 <= count + CntW'(1);
          out_word.region_start <= ins_start;
        end
        S_DONE: out_valid <= 1'b1;
        default: ;
      endcase
    end
  end

endmodule

FILE: hw/rtl/arm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// arm_checker: port-level checks for the address region map
// Watches the handshakes and response codes at the top level.
// ----------------------------------------------------------------------------
module arm_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [31:0] region_start,
  input logic [31:0] region_length
);
  import arm_pkg::*;

  // Hold the status and region start while stalled.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(region_start))
    else $error("response changed while stalled");

  // Drop region fields on any failure.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && status != ST_OK |-> region_start == '0 && region_length == '0)
    else $error("fields set on failure");

  // Never take a command while a response is waiting.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("command taken with response pending");

  // One response per command: no new command the cycle after one is taken.
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second command taken back to back");
endmodule

bind address_region_map arm_checker u_arm_checker (
  .clk           (clk),
  .rst           (rst),
  .in_valid      (req.valid),
  .in_ready      (req.ready),
  .out_valid     (rsp.valid),
  .out_ready     (rsp.ready),
  .status        (rsp.data.status),
  .region_start  (rsp.data.region_start),
  .region_length (rsp.data.region_length)
);
